/* rtl/sfws_pkg.sv */
// Shared types, constants and widths for the SPI flash write sequencer.
// Used by the front, queue, back and top-level modules; depends on nothing.
package sfws_pkg;

   localparam int PAGE_BYTES   = 256;
   localparam int SECTOR_BYTES = 4096;
   localparam int FLASH_BYTES  = 16777216;

   localparam int ADDR_W       = 24;
   localparam int LEN_W        = 25;
   localparam int PAGE_W       = $clog2(PAGE_BYTES);
   localparam int CHUNK_W      = PAGE_W + 1;
   localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
   localparam int SECTOR_W     = ADDR_W - SECTOR_SHIFT;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = QPTR_W + 1;
   localparam int STEP_W       = 3;

   localparam logic [1:0] MODE_START  = 2'd0;
   localparam logic [1:0] MODE_DATA   = 2'd1;
   localparam logic [1:0] MODE_STATUS = 2'd2;

   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_POLL  = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_LENGTH = 2'd1;
   localparam logic [1:0] ERR_PLACE  = 2'd2;

   localparam logic [7:0] CMD_WREN  = 8'h06;
   localparam logic [7:0] CMD_RDSR  = 8'h05;
   localparam logic [7:0] CMD_SE    = 8'h20;
   localparam logic [7:0] CMD_PP    = 8'h02;
   localparam int         BUSY_BIT  = 0;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_DATA,
      PH_EPOLL,
      PH_PPOLL
   } phase_type;

   typedef enum logic [2:0] {
      OP_ERR_LENGTH,
      OP_ERR_PLACE,
      OP_DONE,
      OP_POLL,
      OP_ERASE,
      OP_PROG,
      OP_DATA
   } op_type;

   // One unit of work handed from the front to the back.
   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   addr;
      logic [7:0]          data;
      logic                close;
   } action_type;

endpackage

/* rtl/sfws_front.sv */
// Front end: takes input words, tracks the job state and makes at most one action per word.
// Depends on sfws_pkg.
module sfws_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [1:0]                  mode,
   input  logic [sfws_pkg::ADDR_W-1:0] start_address,
   input  logic [sfws_pkg::LEN_W-1:0]  job_length,
   input  logic [7:0]                  data_byte,
   input  logic [7:0]                  status_byte,
   output logic                        act_push,
   output sfws_pkg::action_type        act
);

   localparam logic [sfws_pkg::LEN_W-1:0] FLASH_LEN = sfws_pkg::LEN_W'(sfws_pkg::FLASH_BYTES);
   localparam logic [sfws_pkg::CHUNK_W-1:0] PAGE_LEN =
      sfws_pkg::CHUNK_W'(sfws_pkg::PAGE_BYTES);

   sfws_pkg::phase_type               phase_ff, phase_in;
   logic [sfws_pkg::ADDR_W-1:0]       addr_ff, addr_in;
   logic [sfws_pkg::LEN_W-1:0]        remain_ff, remain_in;
   logic [sfws_pkg::CHUNK_W-1:0]      chunk_ff, chunk_in;
   logic [sfws_pkg::SECTOR_W-1:0]     sector_ff, sector_in;
   logic                              erased_ff, erased_in;
   logic [7:0]                        held_ff, held_in;

   logic [sfws_pkg::SECTOR_W-1:0]     cur_sector;
   logic [sfws_pkg::CHUNK_W-1:0]      room;
   logic [sfws_pkg::CHUNK_W-1:0]      room_chunk;
   logic [sfws_pkg::ADDR_W-1:0]       addr_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= sfws_pkg::PH_IDLE;
         addr_ff   <= '0;
         remain_ff <= '0;
         chunk_ff  <= '0;
         sector_ff <= '0;
         erased_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         addr_ff   <= addr_in;
         remain_ff <= remain_in;
         chunk_ff  <= chunk_in;
         sector_ff <= sector_in;
         erased_ff <= erased_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   assign cur_sector = addr_ff[sfws_pkg::ADDR_W-1:sfws_pkg::SECTOR_SHIFT];
   assign room       = PAGE_LEN - {1'b0, addr_ff[sfws_pkg::PAGE_W-1:0]};
   assign addr_inc   = addr_ff + sfws_pkg::ADDR_W'(1);

   // A chunk runs to the page boundary or to the end of the job, whichever comes first.
   always_comb begin
      if (remain_ff < sfws_pkg::LEN_W'(room)) begin
         room_chunk = remain_ff[sfws_pkg::CHUNK_W-1:0];
      end else begin
         room_chunk = room;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      addr_in   = addr_ff;
      remain_in = remain_ff;
      chunk_in  = chunk_ff;
      sector_in = sector_ff;
      erased_in = erased_ff;
      held_in   = held_ff;
      act_push  = 1'b0;
      act.op    = sfws_pkg::OP_ERR_PLACE;
      act.addr  = addr_ff;
      act.data  = data_byte;
      act.close = 1'b0;
      if (accept) begin
         act_push = 1'b1;
         priority if (mode == sfws_pkg::MODE_START && phase_ff == sfws_pkg::PH_IDLE) begin
            if (job_length > FLASH_LEN) begin
               act.op = sfws_pkg::OP_ERR_LENGTH;
            end else if (job_length == '0) begin
               act.op = sfws_pkg::OP_DONE;
            end else begin
               act_push  = 1'b0;
               addr_in   = start_address;
               remain_in = job_length;
               chunk_in  = '0;
               erased_in = 1'b0;
               phase_in  = sfws_pkg::PH_DATA;
            end
         end else if (mode == sfws_pkg::MODE_DATA && phase_ff == sfws_pkg::PH_DATA) begin
            if (chunk_ff == '0) begin
               if (!erased_ff || cur_sector != sector_ff) begin
                  act.op    = sfws_pkg::OP_ERASE;
                  sector_in = cur_sector;
                  erased_in = 1'b1;
                  held_in   = data_byte;
                  phase_in  = sfws_pkg::PH_EPOLL;
               end else begin
                  act.op    = sfws_pkg::OP_PROG;
                  act.close = (room_chunk == sfws_pkg::CHUNK_W'(1));
                  chunk_in  = room_chunk - sfws_pkg::CHUNK_W'(1);
                  remain_in = remain_ff - sfws_pkg::LEN_W'(1);
                  addr_in   = addr_inc;
                  phase_in  = act.close ? sfws_pkg::PH_PPOLL : sfws_pkg::PH_DATA;
               end
            end else begin
               act.op    = sfws_pkg::OP_DATA;
               act.close = (chunk_ff == sfws_pkg::CHUNK_W'(1));
               chunk_in  = chunk_ff - sfws_pkg::CHUNK_W'(1);
               remain_in = remain_ff - sfws_pkg::LEN_W'(1);
               addr_in   = addr_inc;
               if (act.close) begin
                  phase_in = sfws_pkg::PH_PPOLL;
               end
            end
         end else if (mode == sfws_pkg::MODE_STATUS &&
                      (phase_ff == sfws_pkg::PH_EPOLL || phase_ff == sfws_pkg::PH_PPOLL)) begin
            if (status_byte[sfws_pkg::BUSY_BIT]) begin
               act.op = sfws_pkg::OP_POLL;
            end else if (phase_ff == sfws_pkg::PH_EPOLL) begin
               // The erase finished: open the program frame with the byte held back.
               act.op    = sfws_pkg::OP_PROG;
               act.data  = held_ff;
               act.close = (room_chunk == sfws_pkg::CHUNK_W'(1));
               chunk_in  = room_chunk - sfws_pkg::CHUNK_W'(1);
               remain_in = remain_ff - sfws_pkg::LEN_W'(1);
               addr_in   = addr_inc;
               phase_in  = act.close ? sfws_pkg::PH_PPOLL : sfws_pkg::PH_DATA;
            end else if (remain_ff == '0) begin
               act.op   = sfws_pkg::OP_DONE;
               phase_in = sfws_pkg::PH_IDLE;
            end else begin
               act_push = 1'b0;
               phase_in = sfws_pkg::PH_DATA;
            end
         end else begin
            act.op = sfws_pkg::OP_ERR_PLACE;
         end
      end
   end

endmodule

/* rtl/sfws_queue.sv */
// Short action queue between the front and the back, built from registers.
// Depends on sfws_pkg.
module sfws_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sfws_pkg::action_type push_act,
   input  logic                 pop,
   output sfws_pkg::action_type head,
   output logic                 empty,
   output logic                 full
);

   sfws_pkg::action_type              slot_ff [sfws_pkg::QUEUE_DEPTH];
   logic [sfws_pkg::QPTR_W-1:0]       wptr_ff, wptr_in;
   logic [sfws_pkg::QPTR_W-1:0]       rptr_ff, rptr_in;
   logic [sfws_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == sfws_pkg::QCNT_W'(sfws_pkg::QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = do_push ? wptr_ff + sfws_pkg::QPTR_W'(1) : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + sfws_pkg::QPTR_W'(1) : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + sfws_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - sfws_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_act;
      end
   end

endmodule

/* rtl/sfws_back.sv */
// Back end: expands each action into result words, one per cycle while its output register drains.
// Depends on sfws_pkg.
module sfws_back (
   input  logic                 clock,
   input  logic                 reset,
   input  sfws_pkg::action_type head,
   input  logic                 q_empty,
   output logic                 q_pop,
   input  logic                 rsp_pop,
   output logic                 rsp_empty,
   output logic [1:0]           rsp_kind,
   output logic [7:0]           rsp_spi_byte,
   output logic                 rsp_frame_end,
   output logic [1:0]           rsp_error_code,
   output logic                 rsp_last,
   output logic [sfws_pkg::STEP_W-1:0] step
);

   logic [sfws_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        valid_ff, valid_in;
   logic [1:0]                  kind_ff;
   logic [7:0]                  byte_ff;
   logic                        fe_ff;
   logic [1:0]                  err_ff;
   logic                        last_ff;

   logic [1:0]                  w_kind;
   logic [7:0]                  w_byte;
   logic                        w_fe;
   logic [1:0]                  w_err;
   logic                        w_last;
   logic                        load;

   // Word number step of the current action.
   always_comb begin
      w_kind = sfws_pkg::KIND_BYTE;
      w_byte = 8'h00;
      w_fe   = 1'b0;
      w_err  = sfws_pkg::ERR_NONE;
      w_last = 1'b0;
      unique case (head.op)
         sfws_pkg::OP_ERR_LENGTH: begin
            w_kind = sfws_pkg::KIND_ERROR;
            w_err  = sfws_pkg::ERR_LENGTH;
            w_last = 1'b1;
         end
         sfws_pkg::OP_ERR_PLACE: begin
            w_kind = sfws_pkg::KIND_ERROR;
            w_err  = sfws_pkg::ERR_PLACE;
            w_last = 1'b1;
         end
         sfws_pkg::OP_DONE: begin
            w_kind = sfws_pkg::KIND_DONE;
            w_last = 1'b1;
         end
         sfws_pkg::OP_POLL: begin
            w_kind = sfws_pkg::KIND_POLL;
            w_byte = sfws_pkg::CMD_RDSR;
            w_last = 1'b1;
         end
         sfws_pkg::OP_ERASE, sfws_pkg::OP_PROG: begin
            unique case (step_ff)
               3'd0: begin
                  w_byte = sfws_pkg::CMD_WREN;
                  w_fe   = 1'b1;
               end
               3'd1: w_byte = (head.op == sfws_pkg::OP_ERASE) ? sfws_pkg::CMD_SE : sfws_pkg::CMD_PP;
               3'd2: w_byte = head.addr[23:16];
               3'd3: w_byte = head.addr[15:8];
               3'd4: begin
                  w_byte = head.addr[7:0];
                  w_fe   = (head.op == sfws_pkg::OP_ERASE);
               end
               3'd5: begin
                  if (head.op == sfws_pkg::OP_ERASE) begin
                     w_kind = sfws_pkg::KIND_POLL;
                     w_byte = sfws_pkg::CMD_RDSR;
                     w_last = 1'b1;
                  end else begin
                     w_byte = head.data;
                     w_fe   = head.close;
                     w_last = !head.close;
                  end
               end
               default: begin
                  w_kind = sfws_pkg::KIND_POLL;
                  w_byte = sfws_pkg::CMD_RDSR;
                  w_last = 1'b1;
               end
            endcase
         end
         sfws_pkg::OP_DATA: begin
            if (step_ff == '0) begin
               w_byte = head.data;
               w_fe   = head.close;
               w_last = !head.close;
            end else begin
               w_kind = sfws_pkg::KIND_POLL;
               w_byte = sfws_pkg::CMD_RDSR;
               w_last = 1'b1;
            end
         end
         default: begin
            w_kind = sfws_pkg::KIND_ERROR;
            w_err  = sfws_pkg::ERR_PLACE;
            w_last = 1'b1;
         end
      endcase
   end

   // A new word moves in whenever the output register is free or being drained.
   assign load  = !q_empty && (!valid_ff || rsp_pop);
   assign q_pop = load && w_last;

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      if (load) begin
         step_in  = w_last ? '0 : step_ff + sfws_pkg::STEP_W'(1);
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= w_kind;
         byte_ff <= w_byte;
         fe_ff   <= w_fe;
         err_ff  <= w_err;
         last_ff <= w_last;
      end
   end

   assign rsp_empty      = !valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_spi_byte   = byte_ff;
   assign rsp_frame_end  = fe_ff;
   assign rsp_error_code = err_ff;
   assign rsp_last       = last_ff;
   assign step           = step_ff;

endmodule

/* rtl/spi_flash_write_sequencer_core.sv */
// Top level of the SPI flash write sequencer: front end, action queue and back end.
// Depends on sfws_pkg, sfws_front, sfws_queue and sfws_back.

// An input word is taken whenever the four-entry action queue between the front and back
// ends has room, so words may arrive back to back. The back end then sends one result word
// per cycle out of its output register while popped: an erase item yields six words, a
// data byte or ready status that opens a page program six or seven, a later data byte one
// or two, and every other item at most one. The sustained rate is thus set by the back
// end's one-word-per-cycle expansion and by how fast the result side pops. Addresses wrap
// at 24 bits and the status poll delay is left to the consumer of the poll requests.
module spi_flash_write_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_mode,
   input  logic [23:0] req_start_address,
   input  logic [24:0] req_job_length,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_status_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_spi_byte,
   output logic        rsp_frame_end,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_last
);

   logic                              accept;
   logic                              act_push;
   sfws_pkg::action_type              act;
   sfws_pkg::action_type              head;
   logic                              q_empty;
   logic                              q_full;
   logic                              q_pop;
   logic [sfws_pkg::STEP_W-1:0]       step;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   sfws_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .mode          (req_mode),
      .start_address (req_start_address),
      .job_length    (req_job_length),
      .data_byte     (req_data_byte),
      .status_byte   (req_status_byte),
      .act_push      (act_push),
      .act           (act)
   );

   sfws_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (act_push),
      .push_act (act),
      .pop      (q_pop),
      .head     (head),
      .empty    (q_empty),
      .full     (q_full)
   );

   sfws_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_kind       (rsp_kind),
      .rsp_spi_byte   (rsp_spi_byte),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last),
      .step           (step)
   );

   // Poll, done and error words always close the run of words for their item.
   a_nonbyte_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind != sfws_pkg::KIND_BYTE) |-> rsp_last)
      else $error("non-byte result word is not marked last");

   // Only shifted bytes may close a chip-select frame.
   a_frame_end_byte: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_frame_end) |-> (rsp_kind == sfws_pkg::KIND_BYTE))
      else $error("frame end on a word that is not a byte");

   // An error code appears exactly on error words.
   a_error_code: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_kind == sfws_pkg::KIND_ERROR) == (rsp_error_code != sfws_pkg::ERR_NONE)))
      else $error("error code does not match word kind");

   // The expansion counter never runs past the longest action.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step <= sfws_pkg::STEP_W'(6))
      else $error("expansion step out of range");

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for spi_flash_write_sequencer_core: drives write jobs, data
// and status words, predicts every command word and compares them as they are popped.
// Depends on rtl/sfws_pkg.sv and rtl/spi_flash_write_sequencer_core.sv.
module tb_top;

   localparam logic [1:0] MODE_SPARE  = 2'd3;
   localparam int         QUIET_LIMIT = 5000;
   localparam int         RANDOM_WORDS = 390;
   localparam int         STEADY_WORDS = 60;

   typedef struct {
      logic [1:0] kind;
      logic [7:0] spi_byte;
      logic       frame_end;
      logic [1:0] error_code;
      logic       last;
   } cmd_word_type;

   // Tracks the sequencer's job state and keeps the command words it must produce.
   class flash_cmd_scoreboard;
      sfws_pkg::phase_type             seq_phase;
      logic [sfws_pkg::ADDR_W-1:0]     next_addr;
      logic [sfws_pkg::LEN_W-1:0]      bytes_left;
      logic [sfws_pkg::CHUNK_W-1:0]    chunk_left;
      logic [sfws_pkg::SECTOR_W-1:0]   erased_sec;
      logic                            erased_ok;
      logic [7:0]                      held_data;
      cmd_word_type                    command_stream[$];
      int                              errors;

      function new();
         seq_phase  = sfws_pkg::PH_IDLE;
         next_addr  = '0;
         bytes_left = '0;
         chunk_left = '0;
         erased_sec = '0;
         erased_ok  = 1'b0;
         held_data  = '0;
         errors     = 0;
      endfunction

      function void queue_word(logic [1:0] kind, logic [7:0] b, logic fe, logic [1:0] err);
         cmd_word_type w;
         w.kind       = kind;
         w.spi_byte   = b;
         w.frame_end  = fe;
         w.error_code = err;
         w.last       = 1'b0;
         command_stream.push_back(w);
      endfunction

      function void send_address(logic [sfws_pkg::ADDR_W-1:0] a, logic close);
         queue_word(sfws_pkg::KIND_BYTE, a[23:16], 1'b0, sfws_pkg::ERR_NONE);
         queue_word(sfws_pkg::KIND_BYTE, a[15:8], 1'b0, sfws_pkg::ERR_NONE);
         queue_word(sfws_pkg::KIND_BYTE, a[7:0], close, sfws_pkg::ERR_NONE);
      endfunction

      function void take_data(logic [7:0] b);
         chunk_left = chunk_left - 1'b1;
         bytes_left = bytes_left - 1'b1;
         next_addr  = next_addr + 1'b1;
         if (chunk_left == 0) begin
            queue_word(sfws_pkg::KIND_BYTE, b, 1'b1, sfws_pkg::ERR_NONE);
            queue_word(sfws_pkg::KIND_POLL, sfws_pkg::CMD_RDSR, 1'b0, sfws_pkg::ERR_NONE);
            seq_phase = sfws_pkg::PH_PPOLL;
         end else begin
            queue_word(sfws_pkg::KIND_BYTE, b, 1'b0, sfws_pkg::ERR_NONE);
         end
      endfunction

      // A chunk ends at the next page boundary or at the end of the job.
      function void open_page(logic [7:0] b);
         int room;
         room = sfws_pkg::PAGE_BYTES - int'(next_addr % sfws_pkg::PAGE_BYTES);
         chunk_left = (int'(bytes_left) < room) ? sfws_pkg::CHUNK_W'(bytes_left)
                                                : sfws_pkg::CHUNK_W'(room);
         queue_word(sfws_pkg::KIND_BYTE, sfws_pkg::CMD_WREN, 1'b1, sfws_pkg::ERR_NONE);
         queue_word(sfws_pkg::KIND_BYTE, sfws_pkg::CMD_PP, 1'b0, sfws_pkg::ERR_NONE);
         send_address(next_addr, 1'b0);
         seq_phase = sfws_pkg::PH_DATA;
         take_data(b);
      endfunction

      function void note_request(logic [1:0] mode, logic [sfws_pkg::ADDR_W-1:0] addr,
                                 logic [sfws_pkg::LEN_W-1:0] len, logic [7:0] data,
                                 logic [7:0] status);
         int                              before_count;
         cmd_word_type                    w;
         logic [sfws_pkg::SECTOR_W-1:0]   sector;
         before_count = command_stream.size();
         if (mode == sfws_pkg::MODE_START && seq_phase == sfws_pkg::PH_IDLE) begin
            if (int'(len) > sfws_pkg::FLASH_BYTES) begin
               queue_word(sfws_pkg::KIND_ERROR, 8'h00, 1'b0, sfws_pkg::ERR_LENGTH);
            end else if (len == 0) begin
               queue_word(sfws_pkg::KIND_DONE, 8'h00, 1'b0, sfws_pkg::ERR_NONE);
            end else begin
               next_addr  = addr;
               bytes_left = len;
               chunk_left = '0;
               erased_ok  = 1'b0;
               seq_phase  = sfws_pkg::PH_DATA;
            end
         end else if (mode == sfws_pkg::MODE_DATA && seq_phase == sfws_pkg::PH_DATA) begin
            if (chunk_left == 0) begin
               sector = sfws_pkg::SECTOR_W'(next_addr / sfws_pkg::SECTOR_BYTES);
               if (!erased_ok || sector != erased_sec) begin
                  queue_word(sfws_pkg::KIND_BYTE, sfws_pkg::CMD_WREN, 1'b1,
                             sfws_pkg::ERR_NONE);
                  queue_word(sfws_pkg::KIND_BYTE, sfws_pkg::CMD_SE, 1'b0, sfws_pkg::ERR_NONE);
                  send_address(next_addr, 1'b1);
                  queue_word(sfws_pkg::KIND_POLL, sfws_pkg::CMD_RDSR, 1'b0,
                             sfws_pkg::ERR_NONE);
                  erased_sec = sector;
                  erased_ok  = 1'b1;
                  held_data  = data;
                  seq_phase  = sfws_pkg::PH_EPOLL;
               end else begin
                  open_page(data);
               end
            end else begin
               take_data(data);
            end
         end else if (mode == sfws_pkg::MODE_STATUS &&
                      (seq_phase == sfws_pkg::PH_EPOLL ||
                       seq_phase == sfws_pkg::PH_PPOLL)) begin
            if (status[sfws_pkg::BUSY_BIT]) begin
               queue_word(sfws_pkg::KIND_POLL, sfws_pkg::CMD_RDSR, 1'b0, sfws_pkg::ERR_NONE);
            end else if (seq_phase == sfws_pkg::PH_EPOLL) begin
               open_page(held_data);
            end else if (bytes_left == 0) begin
               queue_word(sfws_pkg::KIND_DONE, 8'h00, 1'b0, sfws_pkg::ERR_NONE);
               seq_phase = sfws_pkg::PH_IDLE;
            end else begin
               // Ready between chunks: nothing is sent until the next data byte.
               seq_phase = sfws_pkg::PH_DATA;
            end
         end else begin
            queue_word(sfws_pkg::KIND_ERROR, 8'h00, 1'b0, sfws_pkg::ERR_PLACE);
         end
         if (command_stream.size() > before_count) begin
            w = command_stream.pop_back();
            w.last = 1'b1;
            command_stream.push_back(w);
         end
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 10)
            $display("%s", msg);
      endfunction

      function void check_response(logic [1:0] kind, logic [7:0] b, logic fe,
                                   logic [1:0] err, logic last);
         cmd_word_type w;
         if (command_stream.size() == 0) begin
            report($sformatf("unexpected word: kind=%0d byte=%02h end=%0d err=%0d last=%0d",
                             kind, b, fe, err, last));
         end else begin
            w = command_stream.pop_front();
            if (kind !== w.kind || b !== w.spi_byte || fe !== w.frame_end ||
                err !== w.error_code || last !== w.last)
               report($sformatf({"word mismatch: expected kind=%0d byte=%02h end=%0d ",
                                 "err=%0d last=%0d, got kind=%0d byte=%02h end=%0d ",
                                 "err=%0d last=%0d"},
                                w.kind, w.spi_byte, w.frame_end, w.error_code, w.last,
                                kind, b, fe, err, last));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [1:0]  req_mode = sfws_pkg::MODE_START;
   logic [23:0] req_start_address = '0;
   logic [24:0] req_job_length = '0;
   logic [7:0]  req_data_byte = '0;
   logic [7:0]  req_status_byte = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_spi_byte;
   logic        rsp_frame_end;
   logic [1:0]  rsp_error_code;
   logic        rsp_last;

   flash_cmd_scoreboard sb = new();
   bit steady = 1'b0;
   int stall_left = 0;
   int quiet_cycles = 0;

   spi_flash_write_sequencer_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_mode          (req_mode),
      .req_start_address (req_start_address),
      .req_job_length    (req_job_length),
      .req_data_byte     (req_data_byte),
      .req_status_byte   (req_status_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_kind          (rsp_kind),
      .rsp_spi_byte      (rsp_spi_byte),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_error_code    (rsp_error_code),
      .rsp_last          (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Result side: pops with random stall bursts, none once the run turns steady.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         sb.check_response(rsp_kind, rsp_spi_byte, rsp_frame_end, rsp_error_code, rsp_last);
      if (stall_left > 0) begin
         stall_left--;
         rsp_pop <= 1'b0;
      end else if (!steady && $urandom_range(0, 15) == 0) begin
         stall_left = $urandom_range(1, 17) - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic drive_word(input logic [1:0] mode, input logic [23:0] addr,
                             input logic [24:0] len, input logic [7:0] data,
                             input logic [7:0] status);
      req_push          <= 1'b1;
      req_mode          <= mode;
      req_start_address <= addr;
      req_job_length    <= len;
      req_data_byte     <= data;
      req_status_byte   <= status;
      do @(posedge clock); while (req_full);
      sb.note_request(mode, addr, len, data, status);
      if (!steady && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // Picks a word that fits the current job state; noisy words land anywhere.
   task automatic next_word(input bit noisy);
      logic [1:0]  mode;
      logic [23:0] addr;
      logic [24:0] len;
      logic [7:0]  data;
      logic [7:0]  status;
      int          pick;
      addr   = 24'($urandom);
      len    = 25'($urandom);
      data   = 8'($urandom);
      status = 8'($urandom);
      if (noisy && $urandom_range(0, 99) < 10) begin
         mode = 2'($urandom_range(0, 3));
         // An accepted huge job would never finish, so idle starts must be rejected.
         if (mode == sfws_pkg::MODE_START && sb.seq_phase == sfws_pkg::PH_IDLE &&
             len != 0 && int'(len) <= sfws_pkg::FLASH_BYTES) begin
            len[24] = 1'b1;
            if (int'(len) == sfws_pkg::FLASH_BYTES)
               len = len + 1'b1;
         end
      end else begin
         unique case (sb.seq_phase)
            sfws_pkg::PH_IDLE: begin
               mode = sfws_pkg::MODE_START;
               pick = $urandom_range(0, 9);
               if (pick < 5)
                  addr[7:0] = 8'(256 - $urandom_range(1, 20));
               else if (pick < 7)
                  addr[11:0] = 12'(4096 - $urandom_range(1, 40));
               else if (pick == 7)
                  addr = 24'hFFFFFF - 24'($urandom_range(0, 15));
               else if (pick == 8)
                  addr[7:0] = 8'h00;
               pick = $urandom_range(0, 99);
               if (pick < 8)
                  len = '0;
               else if (pick < 78)
                  len = 25'($urandom_range(1, 24));
               else if (pick < 94)
                  len = 25'($urandom_range(25, 70));
               else
                  len = 25'($urandom_range(200, 300));
            end
            sfws_pkg::PH_DATA: mode = sfws_pkg::MODE_DATA;
            default: begin
               mode = sfws_pkg::MODE_STATUS;
               status[sfws_pkg::BUSY_BIT] = ($urandom_range(0, 99) < 30);
            end
         endcase
      end
      drive_word(mode, addr, len, data, status);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Words out of place while idle, rejected job lengths and an empty job.
      drive_word(sfws_pkg::MODE_DATA, 24'h000000, 25'h0000000, 8'hFF, 8'h00);
      drive_word(sfws_pkg::MODE_STATUS, 24'hFFFFFF, 25'h1FFFFFF, 8'h00, 8'hFF);
      drive_word(MODE_SPARE, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF, 8'hFF);
      drive_word(sfws_pkg::MODE_START, 24'hFFFFFF, 25'h1FFFFFF, 8'h00, 8'h00);
      drive_word(sfws_pkg::MODE_START, 24'h123456, 25'h1000001, 8'h00, 8'h00);
      drive_word(sfws_pkg::MODE_START, 24'h000000, 25'h0000000, 8'h00, 8'h00);
      // A three-byte job at the top of flash wraps into sector zero.
      drive_word(sfws_pkg::MODE_START, 24'hFFFFFE, 25'd3, 8'h00, 8'h00);
      drive_word(sfws_pkg::MODE_START, 24'h000000, 25'h1FFFFFF, 8'hFF, 8'hFF);
      drive_word(sfws_pkg::MODE_STATUS, 24'h000000, 25'h0, 8'h00, 8'h00);
      drive_word(sfws_pkg::MODE_DATA, 24'h000000, 25'h0, 8'hFF, 8'h00);
      drive_word(sfws_pkg::MODE_DATA, 24'h000000, 25'h0, 8'h11, 8'h00);
      drive_word(sfws_pkg::MODE_STATUS, 24'h000000, 25'h0, 8'h00, 8'h01);
      drive_word(sfws_pkg::MODE_STATUS, 24'h000000, 25'h0, 8'h00, 8'hFE);
      drive_word(sfws_pkg::MODE_DATA, 24'h000000, 25'h0, 8'h00, 8'h00);
      drive_word(sfws_pkg::MODE_STATUS, 24'h000000, 25'h0, 8'h00, 8'hFF);
      drive_word(sfws_pkg::MODE_STATUS, 24'h000000, 25'h0, 8'h00, 8'h00);
      drive_word(sfws_pkg::MODE_DATA, 24'h000000, 25'h0, 8'h5A, 8'h00);
      drive_word(sfws_pkg::MODE_STATUS, 24'h000000, 25'h0, 8'h00, 8'h00);
      drive_word(sfws_pkg::MODE_STATUS, 24'h000000, 25'h0, 8'h00, 8'h00);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS - STEADY_WORDS)
            steady = 1'b1;
         next_word(1'b1);
      end
      while (sb.seq_phase != sfws_pkg::PH_IDLE)
         next_word(1'b0);

      // A job as long as the whole flash is opened last, since it never completes.
      drive_word(sfws_pkg::MODE_START, 24'h000000, 25'(sfws_pkg::FLASH_BYTES), 8'h00, 8'h00);
      drive_word(sfws_pkg::MODE_DATA, 24'h000000, 25'h0, 8'hC3, 8'h00);
      drive_word(sfws_pkg::MODE_STATUS, 24'h000000, 25'h0, 8'h00, 8'h80);
      drive_word(sfws_pkg::MODE_DATA, 24'h000000, 25'h0, 8'h3C, 8'h00);
      req_push <= 1'b0;

      while (sb.command_stream.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.command_stream.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
